// ----- design/gsbp_pkg.sv -----
// ----------------------------------------------------------------------------
// gsbp_pkg - shared definitions of the grid bit packer
// Status codes, configuration register indexes, the code width and the
// status word that the digit packer hands to the control logic.
// ----------------------------------------------------------------------------
package gsbp_pkg;

  // widest packed code, in bits
  localparam int CODE_W      = 31;
  localparam int BITS_W      = 6;
  localparam int STATUS_W    = 3;
  localparam int CFG_INDEX_W = 3;

  // frame status codes
  localparam logic [STATUS_W-1:0] STATUS_OK        = 3'd0;
  localparam logic [STATUS_W-1:0] STATUS_CONSTANT  = 3'd1;
  localparam logic [STATUS_W-1:0] STATUS_BAD_WIDTH = 3'd2;
  localparam logic [STATUS_W-1:0] STATUS_BAD_RANGE = 3'd3;
  localparam logic [STATUS_W-1:0] STATUS_NO_ROOM   = 3'd4;

  // configuration register indexes
  localparam logic [CFG_INDEX_W-1:0] CFG_RANGE_MINIMUM   = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_RANGE_MAXIMUM   = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_BITS_PER_VALUE  = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] CFG_BUFFER_CAPACITY = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] CFG_POINT_COUNT     = 3'd4;

  // legal packed widths
  localparam logic [BITS_W-1:0] MIN_BITS = 6'd2;
  localparam logic [BITS_W-1:0] MAX_BITS = 6'd31;

  // digit packer status seen by the control logic
  typedef struct packed {
    logic       busy;       // code bits still to place
    logic       emit;       // next step completes a byte
    logic [7:0] full_byte;  // byte completed by the next step
    logic       fill_nz;    // partial byte holds bits
    logic [7:0] partial;    // partial byte as it stands
  } pk_status_t;

endpackage

// ----- design/grid_simple_bit_packer.sv -----
// ----------------------------------------------------------------------------
// grid_simple_bit_packer - simple packing of a fixed-point sample grid
// Scales each sample of a frame to an unsigned code of bits_per_value bits and
// packs the codes MSB first into a byte stream, with a frame report at the end.
// ----------------------------------------------------------------------------
// One sample word is taken at a time. A packed sample passes the accept and
// select states, the three-stage quantizer, the packer state with one step per
// byte-wide digit (a step waits while the output cannot take a byte), and the
// flush and done states. A skipped sample goes from select to flush and done.
// The first sample of a frame first passes the check and decide states and, for
// a good frame, the bit-serial exponent search. Bytes leave through one output
// register at up to one per cycle while out_stall_i is low; one byte is held back
// inside each sample so that the frame's last byte can carry the frame report.
module grid_simple_bit_packer
  import gsbp_pkg::*;
#(
  parameter int SAMPLE_WIDTH  = 48,
  parameter int FRACTION_BITS = 16
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // configuration
  input  logic                           cfg_write_i,
  input  logic        [CFG_INDEX_W-1:0]  cfg_index_i,
  input  logic        [SAMPLE_WIDTH-1:0] cfg_data_i,
  // sample words
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic signed [SAMPLE_WIDTH-1:0] sample_i,
  input  logic                           is_missing_i,
  input  logic                           end_of_grid_i,
  // packed words
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic        [7:0]              packed_byte_o,
  output logic                           byte_valid_o,
  output logic                           frame_done_o,
  output logic        [STATUS_W-1:0]     status_o,
  output logic signed [6:0]              scale_exponent_o,
  output logic        [23:0]             byte_total_o
);

  localparam int SHIFT_W  = $clog2(SAMPLE_WIDTH + 32);
  localparam int EXP_BASE = SAMPLE_WIDTH + 1 - FRACTION_BITS;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CHECK,
    ST_DECIDE,
    ST_SEARCH,
    ST_SELECT,
    ST_QUANT,
    ST_PACK,
    ST_FLUSH,
    ST_DONE
  } state_e;

  state_e state_q;

  // configuration registers
  logic signed [SAMPLE_WIDTH-1:0] range_min_q;
  logic signed [SAMPLE_WIDTH-1:0] range_max_q;
  logic        [BITS_W-1:0]       bits_q;
  logic        [23:0]             capacity_q;
  logic        [23:0]             points_q;

  // current word and frame state
  logic signed [SAMPLE_WIDTH-1:0] sample_q;
  logic                           missing_q;
  logic                           end_q;
  logic                           active_q;
  logic        [STATUS_W-1:0]     frame_status_q;
  logic        [SHIFT_W-1:0]      shift_q;
  logic        [23:0]             count_q;
  logic        [29:0]             prod_q;
  logic                           pend_valid_q;
  logic        [7:0]              pend_byte_q;

  // output register
  logic                out_valid_q;
  logic [7:0]          out_byte_q;
  logic                out_bv_q;
  logic                out_done_q;
  logic [STATUS_W-1:0] out_status_q;
  logic [6:0]          out_exp_q;
  logic [23:0]         out_total_q;

  logic                    bits_ok;
  logic [CODE_W-1:0]       limit;
  logic [27:0]             need;
  logic [SAMPLE_WIDTH-1:0] range_diff;
  logic [STATUS_W-1:0]     decide_status;
  logic                    out_free;
  logic                    can_push;
  logic                    room_left;
  logic                    sample_go;
  logic                    flush_wait;
  logic                    flush_emit;
  logic                    push;
  logic [7:0]              push_byte;
  logic                    done_go;
  logic                    out_load;
  logic [6:0]              fin_exp;
  logic [23:0]             fin_total;

  logic               search_start;
  logic               search_done;
  logic [SHIFT_W-1:0] search_shift;
  logic               quant_start;
  logic               quant_done;
  logic [CODE_W-1:0]  quant_code;
  logic               pack_load;
  logic               pack_step;
  logic               pack_clear;
  pk_status_t         pk;

  // frame checks and limits
  always_comb begin
    bits_ok    = (bits_q >= MIN_BITS) && (bits_q <= MAX_BITS);
    limit      = CODE_W'((32'd1 << bits_q[4:0]) - 32'd1);
    need       = 28'((31'(prod_q) + 31'd7) >> 3);
    range_diff = SAMPLE_WIDTH'(range_max_q - range_min_q);
    priority if (!bits_ok) begin
      decide_status = STATUS_BAD_WIDTH;
    end else if (need > {4'b0000, capacity_q}) begin
      decide_status = STATUS_NO_ROOM;
    end else if (range_max_q < range_min_q) begin
      decide_status = STATUS_BAD_RANGE;
    end else if (range_max_q == range_min_q) begin
      decide_status = STATUS_CONSTANT;
    end else begin
      decide_status = STATUS_OK;
    end
  end

  // sequencing strobes
  always_comb begin
    out_free     = !out_valid_q || !out_stall_i;
    can_push     = !pend_valid_q || out_free;
    room_left    = count_q < capacity_q;
    sample_go    = (frame_status_q == STATUS_OK) && !missing_q && bits_ok;
    search_start = (state_q == ST_DECIDE) && (decide_status == STATUS_OK);
    quant_start  = (state_q == ST_SELECT) && sample_go;
    pack_load    = (state_q == ST_QUANT) && quant_done;
    pack_step    = (state_q == ST_PACK) && pk.busy && can_push;
    flush_wait   = end_q && (frame_status_q == STATUS_OK) && pk.fill_nz && !can_push;
    flush_emit   = (state_q == ST_FLUSH) && end_q && (frame_status_q == STATUS_OK) &&
                   pk.fill_nz && can_push;
    pack_clear   = (state_q == ST_FLUSH) && end_q && !flush_wait;
    push         = ((pack_step && pk.emit) || flush_emit) && room_left;
    push_byte    = (state_q == ST_FLUSH) ? pk.partial : pk.full_byte;
    done_go      = (end_q || pend_valid_q) ? out_free : 1'b1;
    out_load     = (push && pend_valid_q) ||
                   ((state_q == ST_DONE) && done_go && (end_q || pend_valid_q));
    fin_exp      = (frame_status_q == STATUS_OK) ? 7'(EXP_BASE - int'(shift_q)) : 7'd0;
    fin_total    = (frame_status_q == STATUS_OK) ? count_q : 24'd0;
  end

  gsbp_scale_search #(
    .SAMPLE_WIDTH(SAMPLE_WIDTH)
  ) u_search (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(search_start),
    .diff_i (range_diff),
    .limit_i(limit),
    .done_o (search_done),
    .shift_o(search_shift)
  );

  gsbp_quantizer #(
    .SAMPLE_WIDTH(SAMPLE_WIDTH)
  ) u_quant (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (quant_start),
    .sample_i   (sample_q),
    .range_min_i(range_min_q),
    .shift_i    (shift_q),
    .limit_i    (limit),
    .done_o     (quant_done),
    .code_o     (quant_code)
  );

  gsbp_digit_packer u_pack (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .load_i  (pack_load),
    .code_i  (quant_code),
    .bits_i  (bits_q[4:0]),
    .step_i  (pack_step),
    .clear_i (pack_clear),
    .status_o(pk)
  );

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      range_min_q <= '0;
      range_max_q <= '0;
      bits_q      <= 6'd8;
      capacity_q  <= '0;
      points_q    <= '0;
    end else if (cfg_write_i) begin
      unique case (cfg_index_i)
        CFG_RANGE_MINIMUM:   range_min_q <= cfg_data_i;
        CFG_RANGE_MAXIMUM:   range_max_q <= cfg_data_i;
        CFG_BITS_PER_VALUE:  bits_q      <= cfg_data_i[BITS_W-1:0];
        CFG_BUFFER_CAPACITY: capacity_q  <= cfg_data_i[23:0];
        CFG_POINT_COUNT:     points_q    <= cfg_data_i[23:0];
        default: ;
      endcase
    end
  end

  // sequencer, frame state and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= ST_IDLE;
      sample_q       <= '0;
      missing_q      <= 1'b0;
      end_q          <= 1'b0;
      active_q       <= 1'b0;
      frame_status_q <= STATUS_OK;
      shift_q        <= '0;
      count_q        <= '0;
      prod_q         <= '0;
      pend_valid_q   <= 1'b0;
      pend_byte_q    <= '0;
      out_valid_q    <= 1'b0;
      out_byte_q     <= '0;
      out_bv_q       <= 1'b0;
      out_done_q     <= 1'b0;
      out_status_q   <= '0;
      out_exp_q      <= '0;
      out_total_q    <= '0;
    end else begin
      // output word loaded, or taken downstream
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end

      // new byte: the held byte moves out, the new one is held
      if (push) begin
        if (pend_valid_q) begin
          out_byte_q   <= pend_byte_q;
          out_bv_q     <= 1'b1;
          out_done_q   <= 1'b0;
          out_status_q <= '0;
          out_exp_q    <= '0;
          out_total_q  <= '0;
        end
        pend_valid_q <= 1'b1;
        pend_byte_q  <= push_byte;
        count_q      <= count_q + 24'd1;
      end

      unique case (state_q)
        ST_IDLE: begin
          if (in_valid_i) begin
            sample_q  <= sample_i;
            missing_q <= is_missing_i;
            end_q     <= end_of_grid_i;
            state_q   <= active_q ? ST_SELECT : ST_CHECK;
          end
        end
        ST_CHECK: begin
          active_q <= 1'b1;
          prod_q   <= 30'(bits_q) * 30'(points_q);
          state_q  <= ST_DECIDE;
        end
        ST_DECIDE: begin
          frame_status_q <= decide_status;
          shift_q        <= '0;
          state_q        <= (decide_status == STATUS_OK) ? ST_SEARCH : ST_SELECT;
        end
        ST_SEARCH: begin
          if (search_done) begin
            shift_q <= search_shift;
            state_q <= ST_SELECT;
          end
        end
        ST_SELECT: begin
          state_q <= sample_go ? ST_QUANT : ST_FLUSH;
        end
        ST_QUANT: begin
          if (quant_done) begin
            state_q <= ST_PACK;
          end
        end
        ST_PACK: begin
          if (!pk.busy) begin
            state_q <= ST_FLUSH;
          end
        end
        ST_FLUSH: begin
          if (!flush_wait) begin
            state_q <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (done_go) begin
            if (end_q || pend_valid_q) begin
              out_byte_q   <= pend_valid_q ? pend_byte_q : 8'd0;
              out_bv_q     <= pend_valid_q;
              out_done_q   <= end_q;
              out_status_q <= end_q ? frame_status_q : STATUS_OK;
              out_exp_q    <= end_q ? fin_exp : 7'd0;
              out_total_q  <= end_q ? fin_total : 24'd0;
            end
            pend_valid_q <= 1'b0;
            // frame end: back to the reset state
            if (end_q) begin
              active_q       <= 1'b0;
              frame_status_q <= STATUS_OK;
              shift_q        <= '0;
              count_q        <= '0;
            end
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign in_stall_o       = state_q != ST_IDLE;
  assign out_valid_o      = out_valid_q;
  assign packed_byte_o    = out_byte_q;
  assign byte_valid_o     = out_bv_q;
  assign frame_done_o     = out_done_q;
  assign status_o         = out_status_q;
  assign scale_exponent_o = out_exp_q;
  assign byte_total_o     = out_total_q;

endmodule

// ----- design/gsbp_scale_search.sv -----
// ----------------------------------------------------------------------------
// gsbp_scale_search - bit-serial search for the binary scale exponent
// Shifts the grid range in one bit per cycle and stops at the last shift for
// which the rounded, scaled range stays below the code limit.
// ----------------------------------------------------------------------------
module gsbp_scale_search
  import gsbp_pkg::*;
#(
  parameter int SAMPLE_WIDTH = 48,
  localparam int SHIFT_W = $clog2(SAMPLE_WIDTH + 32)
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start_i,
  input  logic [SAMPLE_WIDTH-1:0] diff_i,
  input  logic [CODE_W-1:0]       limit_i,
  output logic                    done_o,
  output logic [SHIFT_W-1:0]      shift_o
);

  logic [SAMPLE_WIDTH-1:0] rest_q;
  logic [33:0]             win_q;
  logic                    sat_q;
  logic                    busy_q;
  logic [SHIFT_W-1:0]      shift_q;

  logic [33:0] win_next;
  logic        sat_next;
  logic [33:0] scaled;
  logic        accept;

  // next window bit comes from the top of the remaining range bits
  always_comb begin
    win_next = {win_q[32:0], rest_q[SAMPLE_WIDTH-1]};
    sat_next = sat_q | win_q[33];
    scaled   = {1'b0, win_next[33:1]} + 34'(win_next[0]);
    accept   = !sat_next && (scaled < {3'b000, limit_i});
  end

  assign done_o  = busy_q && !accept;
  assign shift_o = shift_q;

  // control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      sat_q  <= 1'b0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      sat_q  <= 1'b0;
    end else if (busy_q) begin
      if (accept) begin
        sat_q <= sat_next;
      end else begin
        busy_q <= 1'b0;
      end
    end
  end

  // shift registers
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rest_q  <= diff_i;
      win_q   <= '0;
      shift_q <= '0;
    end else if (busy_q && accept) begin
      rest_q  <= {rest_q[SAMPLE_WIDTH-2:0], 1'b0};
      win_q   <= win_next;
      shift_q <= shift_q + SHIFT_W'(1);
    end
  end

endmodule

// ----- design/gsbp_quantizer.sv -----
// ----------------------------------------------------------------------------
// gsbp_quantizer - sample to packed code
// Three stages: offset from the grid minimum clamped at zero, scaling by the
// frame exponent, then round half up and saturation at the code limit.
// ----------------------------------------------------------------------------
module gsbp_quantizer
  import gsbp_pkg::*;
#(
  parameter int SAMPLE_WIDTH = 48,
  localparam int SHIFT_W = $clog2(SAMPLE_WIDTH + 32)
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start_i,
  input  logic signed [SAMPLE_WIDTH-1:0] sample_i,
  input  logic signed [SAMPLE_WIDTH-1:0] range_min_i,
  input  logic        [SHIFT_W-1:0]      shift_i,
  input  logic        [CODE_W-1:0]       limit_i,
  output logic                           done_o,
  output logic        [CODE_W-1:0]       code_o
);

  localparam int WIDE_W = SAMPLE_WIDTH + CODE_W;
  localparam logic [SHIFT_W-1:0] TOP_SHIFT = SHIFT_W'(WIDE_W);

  logic v1_q, v2_q, v3_q;
  logic [SAMPLE_WIDTH-1:0] gap_q;
  logic [33:0]             win_q;
  logic                    sat_q;
  logic [CODE_W-1:0]       code_q;

  logic [SAMPLE_WIDTH:0]   diff;
  logic [SAMPLE_WIDTH-1:0] gap_d;
  logic [WIDE_W-1:0]       wide;
  logic [33:0]             scaled;
  logic [CODE_W-1:0]       code_d;

  // offset from the minimum, negative offsets clamp to zero
  always_comb begin
    diff = {sample_i[SAMPLE_WIDTH-1], sample_i} - {range_min_i[SAMPLE_WIDTH-1], range_min_i};
    if (!diff[SAMPLE_WIDTH] && (diff != '0)) begin
      gap_d = diff[SAMPLE_WIDTH-1:0];
    end else begin
      gap_d = '0;
    end
  end

  // gap scaled with one extra fraction bit kept for rounding
  assign wide = {gap_q, CODE_W'(0)} >> (TOP_SHIFT - shift_i);

  // round half up, then saturate
  always_comb begin
    scaled = {1'b0, win_q[33:1]} + 34'(win_q[0]);
    if (sat_q || (scaled > {3'b000, limit_i})) begin
      code_d = limit_i;
    end else begin
      code_d = scaled[CODE_W-1:0];
    end
  end

  assign done_o = v3_q;
  assign code_o = code_q;

  // stage valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      v1_q <= start_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  // datapath stages
  always_ff @(posedge clk_i) begin
    gap_q  <= gap_d;
    win_q  <= wide[33:0];
    sat_q  <= |wide[WIDE_W-1:34];
    code_q <= code_d;
  end

endmodule

// ----- design/gsbp_digit_packer.sv -----
// ----------------------------------------------------------------------------
// gsbp_digit_packer - MSB-first code to byte packer
// Holds the code left-aligned in a shift register and moves up to one byte
// worth of bits into the partial byte each step.
// ----------------------------------------------------------------------------
module gsbp_digit_packer
  import gsbp_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              load_i,
  input  logic [CODE_W-1:0] code_i,
  input  logic [4:0]        bits_i,
  input  logic              step_i,
  input  logic              clear_i,
  output pk_status_t        status_o
);

  logic [31:0] sr_q;
  logic [4:0]  rem_q;
  logic [7:0]  partial_q;
  logic [2:0]  fill_q;

  logic [3:0] room;
  logic [3:0] take;
  logic [7:0] mask;
  logic [7:0] placed;
  logic [7:0] sum_partial;
  logic [3:0] sum_fill;

  // one digit: as many bits as fit in the partial byte
  always_comb begin
    room = 4'd8 - {1'b0, fill_q};
    if (rem_q < {1'b0, room}) begin
      take = rem_q[3:0];
    end else begin
      take = room;
    end
    mask        = 8'hFF << (4'd8 - take);
    placed      = (sr_q[31:24] & mask) >> fill_q;
    sum_partial = partial_q | placed;
    sum_fill    = {1'b0, fill_q} + take;
  end

  always_comb begin
    status_o.busy      = rem_q != 5'd0;
    status_o.emit      = sum_fill[3];
    status_o.full_byte = sum_partial;
    status_o.fill_nz   = fill_q != 3'd0;
    status_o.partial   = partial_q;
  end

  // bit counters and partial byte
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rem_q     <= '0;
      fill_q    <= '0;
      partial_q <= '0;
    end else begin
      priority if (clear_i) begin
        fill_q    <= '0;
        partial_q <= '0;
      end else if (load_i) begin
        rem_q <= bits_i;
      end else if (step_i) begin
        rem_q <= rem_q - {1'b0, take};
        if (sum_fill[3]) begin
          fill_q    <= '0;
          partial_q <= '0;
        end else begin
          fill_q    <= sum_fill[2:0];
          partial_q <= sum_partial;
        end
      end
    end
  end

  // code shift register
  always_ff @(posedge clk_i) begin
    if (load_i) begin
      sr_q <= {1'b0, code_i} << (6'd32 - {1'b0, bits_i});
    end else if (step_i) begin
      sr_q <= sr_q << take;
    end
  end

endmodule

// ----- bench/tb_grid_simple_bit_packer.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_grid_simple_bit_packer - self-checking bench of the grid bit packer
// Drives frames of sample words under many register settings. A built-in
// model of the packing predicts every output word, and each one is compared
// field by field as it arrives. Random gaps and stalls hit both channels.
// ----------------------------------------------------------------------------
module tb_grid_simple_bit_packer;
  import gsbp_pkg::*;

  localparam int          SAMPLE_W       = 48;
  localparam int          FRAC_W         = 16;
  localparam logic [63:0] CODE_CEILING   = 64'd1 << 40;
  localparam int          SETTLE_CYCLES  = 150;
  localparam int          WATCHDOG_LIMIT = 3000;
  localparam int          RANDOM_WORDS   = 70;
  localparam int          MAX_REPORTS    = 10;
  localparam logic [23:0] FULL_CAPACITY  = 24'hFFFFFF;
  localparam logic signed [SAMPLE_W-1:0] SAMPLE_LOW  = 48'sh8000_0000_0000;
  localparam logic signed [SAMPLE_W-1:0] SAMPLE_HIGH = 48'sh7FFF_FFFF_FFFF;

  // one sample word as sent
  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample;
    logic                       missing;
    logic                       last;
  } grid_word_t;

  // one packed word as received
  typedef struct packed {
    logic [7:0]          data;
    logic                byte_valid;
    logic                done;
    logic [STATUS_W-1:0] status;
    logic signed [6:0]   exponent;
    logic [23:0]         total;
  } packed_word_t;

  logic                         clk_i         = 1'b0;
  logic                         rst_ni        = 1'b0;
  logic                         cfg_write_i   = 1'b0;
  logic [CFG_INDEX_W-1:0]       cfg_index_i   = '0;
  logic [SAMPLE_W-1:0]          cfg_data_i    = '0;
  logic                         in_valid_i    = 1'b0;
  logic                         in_stall_o;
  logic signed [SAMPLE_W-1:0]   sample_i      = '0;
  logic                         is_missing_i  = 1'b0;
  logic                         end_of_grid_i = 1'b0;
  logic                         out_valid_o;
  logic                         out_stall_i   = 1'b0;
  logic [7:0]                   packed_byte_o;
  logic                         byte_valid_o;
  logic                         frame_done_o;
  logic [STATUS_W-1:0]          status_o;
  logic signed [6:0]            scale_exponent_o;
  logic [23:0]                  byte_total_o;

  // register copies
  logic signed [SAMPLE_W-1:0] reg_minimum  = '0;
  logic signed [SAMPLE_W-1:0] reg_maximum  = '0;
  logic [BITS_W-1:0]          reg_bits     = 6'd8;
  logic [23:0]                reg_capacity = '0;
  logic [23:0]                reg_points   = '0;

  // packing state of the model
  logic [7:0]          acc_byte     = '0;
  int                  acc_fill     = 0;
  logic [23:0]         bytes_out    = '0;
  bit                  frame_open   = 1'b0;
  int                  shift_n      = 0;
  logic [STATUS_W-1:0] frame_status = STATUS_OK;

  grid_word_t   pending_words[$];
  packed_word_t expected_packed[$];
  packed_word_t step_out[$];

  bit word_taken   = 1'b0;
  bit result_taken = 1'b0;
  bit send_quiet   = 1'b0;
  bit recv_quiet   = 1'b0;
  int send_gap     = 0;
  int recv_hold    = 0;
  int idle_cycles  = 0;
  int mismatch_count = 0;
  int checked_count  = 0;
  int sample_count   = 0;
  int frame_count    = 0;
  int random_sent    = 0;

  grid_simple_bit_packer dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_write_i      (cfg_write_i),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .sample_i         (sample_i),
    .is_missing_i     (is_missing_i),
    .end_of_grid_i    (end_of_grid_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .packed_byte_o    (packed_byte_o),
    .byte_valid_o     (byte_valid_o),
    .frame_done_o     (frame_done_o),
    .status_o         (status_o),
    .scale_exponent_o (scale_exponent_o),
    .byte_total_o     (byte_total_o)
  );

  // clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // round half up of d * 2^(n - FRAC_W), saturated at the code ceiling
  function automatic logic [63:0] scale_to_code(input logic [63:0] d, input int n);
    int s;
    s = n - FRAC_W;
    if (s >= 0) begin
      if (d == 64'd0) return 64'd0;
      if (s >= 40 || d >= (CODE_CEILING >> s)) return CODE_CEILING;
      return d << s;
    end
    s = -s;
    if (s > 64) return 64'd0;
    if (s == 64) return d >> 63;
    return (d >> s) + ((d >> (s - 1)) & 64'd1);
  endfunction

  function automatic packed_word_t make_word(input logic [7:0] data, input logic valid);
    packed_word_t w;
    w.data       = data;
    w.byte_valid = valid;
    w.done       = 1'b0;
    w.status     = STATUS_OK;
    w.exponent   = '0;
    w.total      = '0;
    return w;
  endfunction

  function automatic logic [47:0] random48();
    logic [63:0] r;
    r = {$urandom, $urandom};
    return r[47:0];
  endfunction

  // completed byte leaves unless the buffer is full
  task automatic store_byte();
    if (bytes_out < reg_capacity) begin
      step_out.push_back(make_word(acc_byte, 1'b1));
      bytes_out = bytes_out + 24'd1;
    end
    acc_byte = '0;
    acc_fill = 0;
  endtask

  // checks and exponent search on the first word of a frame
  task automatic open_frame();
    logic signed [63:0] mn64, mx64;
    logic [63:0]        span, limit, need;
    int                 n;
    mn64 = reg_minimum;
    mx64 = reg_maximum;
    n = 0;
    frame_open = 1'b1;
    shift_n = 0;
    if (reg_bits < MIN_BITS || reg_bits > MAX_BITS) begin
      frame_status = STATUS_BAD_WIDTH;
      return;
    end
    need = (64'(reg_bits) * 64'(reg_points) + 64'd7) / 64'd8;
    if (need > 64'(reg_capacity)) begin
      frame_status = STATUS_NO_ROOM;
      return;
    end
    if (mx64 < mn64) begin
      frame_status = STATUS_BAD_RANGE;
      return;
    end
    if (mx64 == mn64) begin
      frame_status = STATUS_CONSTANT;
      return;
    end
    span = mx64 - mn64;
    limit = (64'd1 << reg_bits) - 64'd1;
    if (scale_to_code(span, 0) >= limit) begin
      while (n > -80 && scale_to_code(span, n) >= limit) n--;
    end else begin
      while (n < 80 && scale_to_code(span, n + 1) < limit) n++;
    end
    shift_n = n;
    frame_status = STATUS_OK;
  endtask

  // predicts the packed words that one accepted sample word causes
  task automatic pack_sample_word(input grid_word_t w);
    logic signed [63:0] s64, mn64;
    logic [63:0]        gap, cap, code;
    packed_word_t       tail;
    int                 j;
    step_out.delete();
    if (!frame_open) open_frame();
    if (frame_status == STATUS_OK && !w.missing &&
        reg_bits >= MIN_BITS && reg_bits <= MAX_BITS) begin
      s64 = $signed(w.sample);
      mn64 = reg_minimum;
      if (s64 > mn64) gap = s64 - mn64;
      else gap = 64'd0;
      cap = (64'd1 << reg_bits) - 64'd1;
      code = scale_to_code(gap, shift_n);
      if (code > cap) code = cap;
      for (j = int'(reg_bits) - 1; j >= 0; j--) begin
        acc_byte[7 - acc_fill] = code[j];
        acc_fill++;
        if (acc_fill == 8) store_byte();
      end
    end
    // frame end: flush, report on the last word, clear state
    if (w.last) begin
      if (frame_status == STATUS_OK && acc_fill != 0) store_byte();
      if (step_out.size() == 0) step_out.push_back(make_word(8'd0, 1'b0));
      tail = step_out.pop_back();
      tail.done = 1'b1;
      tail.status = frame_status;
      tail.exponent = (frame_status == STATUS_OK) ? 7'(-shift_n) : 7'sd0;
      tail.total = (frame_status == STATUS_OK) ? bytes_out : 24'd0;
      step_out.push_back(tail);
      acc_byte = '0;
      acc_fill = 0;
      bytes_out = '0;
      frame_open = 1'b0;
      frame_status = STATUS_OK;
      shift_n = 0;
    end
    foreach (step_out[i]) expected_packed.push_back(step_out[i]);
  endtask

  task automatic note_mismatch(input packed_word_t got, input packed_word_t want,
                               input bit had_want);
    mismatch_count++;
    if (mismatch_count <= MAX_REPORTS) begin
      if (had_want)
        $display("error: word %0d expected byte %02h v%0b d%0b st%0d exp %0d total %0d",
                 checked_count, want.data, want.byte_valid, want.done, want.status,
                 $signed(want.exponent), want.total);
      else
        $display("error: word %0d arrived with nothing expected", checked_count);
      $display("       got byte %02h v%0b d%0b st%0d exp %0d total %0d",
               got.data, got.byte_valid, got.done, got.status,
               $signed(got.exponent), got.total);
    end
  endtask

  // monitor: checks packed words, predicts from accepted sample words
  always @(posedge clk_i) begin
    packed_word_t got, want;
    grid_word_t   w;
    bit           progress;
    progress = 1'b0;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        got.data       = packed_byte_o;
        got.byte_valid = byte_valid_o;
        got.done       = frame_done_o;
        got.status     = status_o;
        got.exponent   = scale_exponent_o;
        got.total      = byte_total_o;
        checked_count++;
        result_taken = 1'b1;
        progress = 1'b1;
        if (expected_packed.size() == 0) begin
          note_mismatch(got, got, 1'b0);
        end else begin
          want = expected_packed.pop_front();
          if (got.data !== want.data || got.byte_valid !== want.byte_valid ||
              got.done !== want.done || got.status !== want.status ||
              got.exponent !== want.exponent || got.total !== want.total)
            note_mismatch(got, want, 1'b1);
        end
      end
      if (in_valid_i && !in_stall_o) begin
        w.sample  = sample_i;
        w.missing = is_missing_i;
        w.last    = end_of_grid_i;
        pack_sample_word(w);
        sample_count++;
        if (end_of_grid_i) frame_count++;
        word_taken = 1'b1;
        progress = 1'b1;
      end
      // watchdog on handshakes
      if (progress) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("timeout: no handshake for %0d cycles", WATCHDOG_LIMIT);
        $display("Mismatches found");
        $finish;
      end
    end
  end

  // sample driver with random gaps and quiet stretches
  always @(negedge clk_i) begin
    bit         drive_valid;
    grid_word_t w;
    drive_valid = in_valid_i && !word_taken;
    word_taken = 1'b0;
    if (rst_ni && !drive_valid) begin
      if (send_gap > 0) begin
        send_gap--;
      end else if (pending_words.size() != 0) begin
        w = pending_words.pop_front();
        sample_i      <= w.sample;
        is_missing_i  <= w.missing;
        end_of_grid_i <= w.last;
        drive_valid = 1'b1;
        if ($urandom_range(0, 15) == 0) send_quiet = !send_quiet;
        send_gap = send_quiet ? 0 : $urandom_range(0, 6);
      end
    end
    in_valid_i <= drive_valid;
  end

  // receiver stall, drawn per packed word
  always @(negedge clk_i) begin
    if (result_taken) begin
      result_taken = 1'b0;
      if ($urandom_range(0, 15) == 0) recv_quiet = !recv_quiet;
      recv_hold = recv_quiet ? 0 : $urandom_range(0, 6);
    end
    if (recv_hold > 0) begin
      if (out_valid_o) recv_hold--;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  task automatic push_word(input logic signed [SAMPLE_W-1:0] sample, input logic missing,
                           input logic last);
    grid_word_t w;
    w.sample  = sample;
    w.missing = missing;
    w.last    = last;
    pending_words.push_back(w);
  endtask

  // waits for every word to go out, then for the block to go quiet
  task automatic drain_words();
    while (pending_words.size() != 0 || in_valid_i || expected_packed.size() != 0)
      @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_register(input logic [CFG_INDEX_W-1:0] idx,
                                input logic [SAMPLE_W-1:0] value);
    @(negedge clk_i);
    cfg_write_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= value;
    case (idx)
      CFG_RANGE_MINIMUM:   reg_minimum  = value;
      CFG_RANGE_MAXIMUM:   reg_maximum  = value;
      CFG_BITS_PER_VALUE:  reg_bits     = value[BITS_W-1:0];
      CFG_BUFFER_CAPACITY: reg_capacity = value[23:0];
      CFG_POINT_COUNT:     reg_points   = value[23:0];
      default: ;
    endcase
  endtask

  // all five registers, back to back
  task automatic load_setup(input logic signed [SAMPLE_W-1:0] mn,
                            input logic signed [SAMPLE_W-1:0] mx,
                            input logic [BITS_W-1:0] bits, input logic [23:0] cap,
                            input logic [23:0] pts);
    write_register(CFG_RANGE_MINIMUM, mn);
    write_register(CFG_RANGE_MAXIMUM, mx);
    write_register(CFG_BITS_PER_VALUE, 48'(bits));
    write_register(CFG_BUFFER_CAPACITY, 48'(cap));
    write_register(CFG_POINT_COUNT, 48'(pts));
    @(negedge clk_i);
    cfg_write_i <= 1'b0;
  endtask

  initial begin
    logic signed [SAMPLE_W-1:0] mn, mx, s;
    logic [47:0]                span;
    logic [63:0]                r;
    logic [BITS_W-1:0]          bits;
    logic [23:0]                cap, pts;
    int                         kind, len, need, i;

    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // reset values: constant grid with an empty buffer
    push_word(48'sd0, 1'b0, 1'b1);
    drain_words();

    // full-scale range, extreme samples, a skipped word
    load_setup(SAMPLE_LOW, SAMPLE_HIGH, 6'd8, FULL_CAPACITY, 24'd4);
    push_word(SAMPLE_LOW, 1'b0, 1'b0);
    push_word(SAMPLE_HIGH, 1'b0, 1'b0);
    push_word(48'sd0, 1'b1, 1'b0);
    push_word(48'sd0, 1'b0, 1'b0);
    push_word(-48'sd1, 1'b0, 1'b1);
    drain_words();

    // widest code, tiny range: clamp below, saturate above, end on a skipped word
    load_setup(48'sd0, 48'sd1, 6'd31, 24'd100, 24'd4);
    push_word(48'sd0, 1'b0, 1'b0);
    push_word(48'sd1, 1'b0, 1'b0);
    push_word(-48'sd327680, 1'b0, 1'b0);
    push_word(SAMPLE_HIGH, 1'b0, 1'b0);
    push_word(48'sd0, 1'b1, 1'b1);
    drain_words();

    // narrowest code over the full range
    load_setup(SAMPLE_LOW, SAMPLE_HIGH, 6'd2, FULL_CAPACITY, 24'd3);
    push_word(SAMPLE_HIGH, 1'b0, 1'b0);
    push_word(48'sd0, 1'b0, 1'b0);
    push_word(SAMPLE_LOW + 48'sd1, 1'b0, 1'b1);
    drain_words();

    // widths outside the legal span
    load_setup(48'sd0, 48'sd6553600, 6'd1, FULL_CAPACITY, 24'd2);
    push_word(48'sd5, 1'b0, 1'b0);
    push_word(48'sd7, 1'b0, 1'b1);
    drain_words();
    load_setup(48'sd0, 48'sd6553600, 6'd0, FULL_CAPACITY, 24'd1);
    push_word(48'sd9, 1'b0, 1'b1);
    drain_words();
    load_setup(48'sd0, 48'sd6553600, 6'd32, FULL_CAPACITY, 24'd1);
    push_word(48'sd9, 1'b0, 1'b1);
    drain_words();
    load_setup(48'sd0, 48'sd6553600, 6'd63, FULL_CAPACITY, 24'd1);
    push_word(48'sd9, 1'b0, 1'b1);
    drain_words();

    // buffer too small for the point count
    load_setup(48'sd0, 48'sd65536000, 6'd8, 24'd9, 24'd10);
    push_word(48'sd100, 1'b0, 1'b1);
    drain_words();

    // maximum below minimum
    load_setup(SAMPLE_HIGH, SAMPLE_LOW, 6'd16, FULL_CAPACITY, 24'd1);
    push_word(48'sd100, 1'b0, 1'b1);
    drain_words();

    // more samples than announced: bytes past the capacity are dropped
    load_setup(48'sd0, 48'sd268369920, 6'd12, 24'd2, 24'd0);
    push_word(48'sd268369920, 1'b0, 1'b0);
    push_word(48'sd65536, 1'b0, 1'b0);
    push_word(48'sd134217728, 1'b0, 1'b0);
    push_word(48'sd3, 1'b0, 1'b1);
    drain_words();

    // largest point count that still fits the largest buffer
    load_setup(-48'sd65536, 48'sd65536, 6'd7, FULL_CAPACITY, FULL_CAPACITY);
    push_word(48'sd0, 1'b0, 1'b0);
    push_word(48'sd65536, 1'b0, 1'b1);
    drain_words();

    // random frames, mostly well formed
    while (random_sent < RANDOM_WORDS) begin
      kind = $urandom_range(0, 15);
      bits = 6'($urandom_range(2, 31));
      mn = $signed(random48()) >>> $urandom_range(1, 47);
      span = random48() >> $urandom_range(2, 47);
      len = $urandom_range(1, 8);
      pts = 24'(len);
      cap = FULL_CAPACITY;
      case (kind)
        0: bits = $urandom_range(0, 1) ? 6'($urandom_range(0, 1))
                                       : 6'($urandom_range(32, 63));
        1: span = '0;
        6: begin
          mn = SAMPLE_LOW;
          span = 48'hFFFF_FFFF_FFFF;
        end
        default: ;
      endcase
      mx = mn + span;
      if (kind == 2) mx = mn - span - 48'sd1;
      if (kind == 3) begin
        pts = 24'(len + $urandom_range(0, 20));
        need = (int'(bits) * int'(pts) + 7) / 8;
        cap = 24'(need - 1);
      end else if (kind == 4) begin
        pts = '0;
        cap = 24'($urandom_range(0, 3));
      end else if (kind == 5) begin
        need = (int'(bits) * int'(pts) + 7) / 8;
        cap = 24'(need);
      end
      load_setup(mn, mx, bits, cap, pts);
      for (i = 0; i < len; i++) begin
        r = {$urandom, $urandom};
        case ($urandom_range(0, 7))
          0: s = random48();
          1: s = mn - 48'($urandom_range(0, 1000));
          2: s = mx + 48'($urandom_range(0, 1000));
          default: s = mn + 48'(r % (64'(span) + 64'd1));
        endcase
        push_word(s, $urandom_range(0, 7) == 0, i == len - 1);
      end
      random_sent += len;
      drain_words();
    end

    if (expected_packed.size() != 0) begin
      $display("error: %0d expected words never arrived", expected_packed.size());
      mismatch_count += expected_packed.size();
    end
    $display("run: %0d frames, %0d sample words (%0d random), %0d packed words checked",
             frame_count, sample_count, random_sent, checked_count);
    $display("run: widths 0 to 63, empty to full buffers, constant, bad and full ranges");
    if (mismatch_count == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

endmodule

// ----- files.f -----
design/gsbp_pkg.sv
design/gsbp_scale_search.sv
design/gsbp_quantizer.sv
design/gsbp_digit_packer.sv
design/grid_simple_bit_packer.sv
bench/tb_grid_simple_bit_packer.sv
